[rtl/core/asc_pkg.sv]
// Package for the activity sample collector: request structs, phase codes,
// action codes, register indexes and fixed constants. No dependencies.
package asc_pkg;

    // Session phase, as reported on the result
    typedef enum logic [2:0] {
        PH_WAIT        = 3'd0,
        PH_SAMPLE      = 3'd1,
        PH_FILTER      = 3'd2,
        PH_WAIT_SAMPLE = 3'd3,
        PH_WAIT_PUB    = 3'd4
    } t_phase;

    // Action codes of an input request
    localparam logic [1:0] ACT_STEP   = 2'd0;
    localparam logic [1:0] ACT_BUTTON = 2'd1;
    localparam logic [1:0] ACT_ACK    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_UV_LIMIT     = 2'd1;
    localparam logic [1:0] CFG_TICK_LIMIT   = 2'd2;

    localparam int CFG_DATA_W = 24;

    // Register reset values
    localparam logic [7:0]  RST_SAMPLE_COUNT = 8'd10;
    localparam logic [23:0] RST_UV_LIMIT     = 24'd1000;
    localparam logic [15:0] RST_TICK_LIMIT   = 16'd100;

    // 0.75 in Q8.8, and the exposure ceiling
    localparam logic [23:0] SPEED_ZERO_Q8 = 24'd192;
    localparam logic [47:0] EXPOSURE_MAX  = 48'hFFFF_FFFF_FFFF;

    // Serial divider passes: speed quotient, then UV quotient scaled by 256
    localparam int DIV_SPD_ITER = 24;
    localparam int DIV_UV_ITER  = 32;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] speed_sample;
        logic [15:0] uv_sample;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  phase;
        logic        collecting;
        logic        collected;
        logic        paused;
        logic        uv_alarm;
        logic        record_valid;
        logic [15:0] record_speed;
        logic [23:0] record_uv;
    } t_out_req;

endpackage

[rtl/core/activity_sample_collector.sv]
// Activity sample collector: session sequencer with a shared serial divider.
// Depends on asc_pkg.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | i_in_valid, o_in_ready, i_in_data         | in
//  result    | o_out_valid, i_out_ready, o_out_data      | out
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data           | in
//
// A step in the filter phase is accepted in S_IDLE, then the restoring divider in
// S_DIV gives the speed average, then the UV average; S_FIN updates pause,
// history and exposure, and S_ALARM does the alarm compare. Every other request
// is done in the cycle it is accepted. Reset is synchronous and needs no
// clearing pass. A request is taken only while the sequencer is idle and the
// result register is free or being emptied in the same cycle.
module activity_sample_collector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  asc_pkg::t_in_req                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output asc_pkg::t_out_req                 o_out_data,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [asc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import asc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_FIN   = 5'b00100,
        S_ALARM = 5'b01000,
        S_SPARE = 5'b10000
    } t_seq;

    // Configuration
    logic [7:0]  r_cfg_count;
    logic [23:0] r_cfg_uv_limit;
    logic [15:0] r_cfg_tick_limit;

    // Session state
    t_seq        r_seq, n_seq;
    t_phase      r_phase, n_phase;
    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_idx, n_idx;
    logic [23:0] r_spd_sum, n_spd_sum;
    logic [23:0] r_uv_sum, n_uv_sum;
    logic        r_button, n_button;
    logic        r_collected, n_collected;
    logic        r_paused, n_paused;
    logic        r_alarm, n_alarm;
    logic        r_active, n_active;
    logic [47:0] r_expo, n_expo;
    logic [15:0] r_hist0, n_hist0;
    logic [15:0] r_hist1, n_hist1;
    logic [1:0]  r_hist_cnt, n_hist_cnt;

    // Divider and record
    logic [7:0]  r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_pass, n_pass;
    logic [23:0] r_avg_s, n_avg_s;
    logic        r_rec_valid, n_rec_valid;
    logic [15:0] r_rec_speed, n_rec_speed;
    logic [23:0] r_rec_uv, n_rec_uv;

    // Result register
    logic        r_out_valid, n_out_valid;
    t_out_req    r_out, n_out;

    logic        in_acc;
    logic        out_load;
    logic        out_rec;
    logic [7:0]  div_n;
    logic [15:0] tick_inc;
    logic [8:0]  rem_sh;
    logic        rem_ge;
    logic [8:0]  rem_diff;
    logic [7:0]  rem_nx;
    logic [31:0] quo_nx;
    logic [15:0] avg_s16;
    logic [48:0] expo_sum;

    assign o_in_ready  = (r_seq == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign div_n    = (r_cfg_count == 8'd0) ? 8'd1 : r_cfg_count;
    assign tick_inc = (r_tick != 16'hFFFF) ? r_tick + 16'd1 : r_tick;

    // One restoring division step
    assign rem_sh   = {r_rem, r_quo[31]};
    assign rem_ge   = rem_sh >= {1'b0, div_n};
    assign rem_diff = rem_sh - {1'b0, div_n};
    assign rem_nx   = rem_ge ? rem_diff[7:0] : rem_sh[7:0];
    assign quo_nx   = {r_quo[30:0], rem_ge};

    // Speed average with the low-speed floor, then cut to Q8.8
    assign avg_s16  = (r_avg_s < SPEED_ZERO_Q8) ? 16'd0 : r_avg_s[15:0];
    assign expo_sum = {1'b0, r_expo} + {25'd0, r_quo[23:0]};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count      <= RST_SAMPLE_COUNT;
            r_cfg_uv_limit   <= RST_UV_LIMIT;
            r_cfg_tick_limit <= RST_TICK_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_COUNT: r_cfg_count      <= i_cfg_data[7:0];
                CFG_UV_LIMIT:     r_cfg_uv_limit   <= i_cfg_data[23:0];
                CFG_TICK_LIMIT:   r_cfg_tick_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer and session update
    always_comb begin
        n_seq       = r_seq;
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_idx       = r_idx;
        n_spd_sum   = r_spd_sum;
        n_uv_sum    = r_uv_sum;
        n_button    = r_button;
        n_collected = r_collected;
        n_paused    = r_paused;
        n_alarm     = r_alarm;
        n_active    = r_active;
        n_expo      = r_expo;
        n_hist0     = r_hist0;
        n_hist1     = r_hist1;
        n_hist_cnt  = r_hist_cnt;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_avg_s     = r_avg_s;
        n_rec_valid = r_rec_valid;
        n_rec_speed = r_rec_speed;
        n_rec_uv    = r_rec_uv;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        out_load    = 1'b0;
        out_rec     = 1'b0;

        case (r_seq)
            S_IDLE: begin
                if (in_acc) begin
                    out_load = 1'b1;
                    case (i_in_data.action)
                        ACT_BUTTON: n_button = 1'b1;
                        ACT_ACK:    n_collected = 1'b0;
                        ACT_STEP: begin
                            case (r_phase)
                                PH_WAIT: begin
                                    n_idx    = 8'd0;
                                    n_expo   = 48'd0;
                                    n_paused = 1'b0;
                                    n_alarm  = 1'b0;
                                    if (r_button) begin
                                        n_button   = 1'b0;
                                        n_hist0    = 16'd0;
                                        n_hist1    = 16'd0;
                                        n_hist_cnt = 2'd0;
                                        n_active   = 1'b1;
                                        n_phase    = PH_SAMPLE;
                                    end
                                end
                                PH_SAMPLE: begin
                                    n_tick = tick_inc;
                                    if (r_idx == 8'd0) begin
                                        n_spd_sum = {8'd0, i_in_data.speed_sample};
                                        n_uv_sum  = {8'd0, i_in_data.uv_sample};
                                    end else begin
                                        n_spd_sum = r_spd_sum + {8'd0, i_in_data.speed_sample};
                                        n_uv_sum  = r_uv_sum + {8'd0, i_in_data.uv_sample};
                                    end
                                    if (({1'b0, r_idx} + 9'd1) >= {1'b0, div_n}) begin
                                        n_phase = PH_FILTER;
                                    end
                                    if (r_idx != 8'hFF) begin
                                        n_idx = r_idx + 8'd1;
                                    end
                                end
                                PH_FILTER: begin
                                    // result waits for the divider
                                    out_load = 1'b0;
                                    n_tick   = tick_inc;
                                    n_phase  = PH_WAIT_SAMPLE;
                                    n_rem    = 8'd0;
                                    n_quo    = {r_spd_sum, 8'd0};
                                    n_cnt    = 5'(DIV_SPD_ITER - 1);
                                    n_pass   = 1'b0;
                                    n_seq    = S_DIV;
                                end
                                PH_WAIT_SAMPLE: begin
                                    n_tick = tick_inc;
                                    n_idx  = 8'd0;
                                    if (r_button) begin
                                        n_button    = 1'b0;
                                        n_collected = 1'b1;
                                        n_phase     = PH_WAIT_PUB;
                                    end else if (tick_inc >= r_cfg_tick_limit) begin
                                        n_tick  = 16'd0;
                                        n_phase = PH_SAMPLE;
                                    end
                                end
                                PH_WAIT_PUB: begin
                                    if (r_collected) begin
                                        n_active = 1'b0;
                                    end else begin
                                        n_phase = PH_WAIT;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                n_rem = rem_nx;
                n_quo = quo_nx;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    if (!r_pass) begin
                        // speed quotient done, start UV pass
                        n_avg_s = quo_nx[23:0];
                        n_rem   = 8'd0;
                        n_quo   = {r_uv_sum, 8'd0};
                        n_cnt   = 5'(DIV_UV_ITER - 1);
                        n_pass  = 1'b1;
                    end else begin
                        n_seq = S_FIN;
                    end
                end
            end
            S_FIN: begin
                // auto-pause, history and exposure update
                n_rec_valid = 1'b0;
                n_rec_speed = 16'd0;
                n_rec_uv    = 24'd0;
                if ((r_hist_cnt == 2'd2) && (r_hist0 == 16'd0) && (r_hist1 == 16'd0)) begin
                    n_paused = 1'b1;
                end
                if (avg_s16 != 16'd0) begin
                    n_paused = 1'b0;
                end
                if (!n_paused) begin
                    n_rec_valid = 1'b1;
                    n_rec_speed = avg_s16;
                    n_rec_uv    = r_quo[23:0];
                    n_hist1     = r_hist0;
                    n_hist0     = avg_s16;
                    if (r_hist_cnt != 2'd2) begin
                        n_hist_cnt = r_hist_cnt + 2'd1;
                    end
                    n_expo = expo_sum[48] ? EXPOSURE_MAX : expo_sum[47:0];
                end
                n_seq = S_ALARM;
            end
            S_ALARM: begin
                if (r_expo > {16'd0, r_cfg_uv_limit, 8'd0}) begin
                    n_alarm = 1'b1;
                end
                out_load = 1'b1;
                out_rec  = 1'b1;
                n_seq    = S_IDLE;
            end
            default: n_seq = S_IDLE;
        endcase

        // Result register load
        if (out_load) begin
            n_out_valid        = 1'b1;
            n_out.phase        = n_phase;
            n_out.collecting   = n_active;
            n_out.collected    = n_collected;
            n_out.paused       = n_paused;
            n_out.uv_alarm     = n_alarm;
            n_out.record_valid = out_rec ? r_rec_valid : 1'b0;
            n_out.record_speed = out_rec ? r_rec_speed : 16'd0;
            n_out.record_uv    = out_rec ? r_rec_uv : 24'd0;
        end
    end

    // Control and session registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= S_IDLE;
            r_phase     <= PH_WAIT;
            r_tick      <= 16'd0;
            r_idx       <= 8'd0;
            r_spd_sum   <= 24'd0;
            r_uv_sum    <= 24'd0;
            r_button    <= 1'b0;
            r_collected <= 1'b0;
            r_paused    <= 1'b0;
            r_alarm     <= 1'b0;
            r_active    <= 1'b0;
            r_expo      <= 48'd0;
            r_hist0     <= 16'd0;
            r_hist1     <= 16'd0;
            r_hist_cnt  <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_idx       <= n_idx;
            r_spd_sum   <= n_spd_sum;
            r_uv_sum    <= n_uv_sum;
            r_button    <= n_button;
            r_collected <= n_collected;
            r_paused    <= n_paused;
            r_alarm     <= n_alarm;
            r_active    <= n_active;
            r_expo      <= n_expo;
            r_hist0     <= n_hist0;
            r_hist1     <= n_hist1;
            r_hist_cnt  <= n_hist_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Divider and result payload
    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_pass      <= n_pass;
        r_avg_s     <= n_avg_s;
        r_rec_valid <= n_rec_valid;
        r_rec_speed <= n_rec_speed;
        r_rec_uv    <= n_rec_uv;
        r_out       <= n_out;
    end

endmodule
